// ===== src/assert_macros.svh =====
// assertion macros shared by the sorted key table rtl
// expects signals named clk and rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define SKT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/skt_pkg.sv =====
// shared types and constants for the sorted key table
// no dependencies; used by skt_cell and sorted_key_table
package skt_pkg;

  localparam int CAPACITY    = 16;
  localparam int HANDLE_BITS = 16;
  localparam int KEY_BITS    = 31;
  localparam int CMD_BITS    = 3;
  localparam int STATUS_BITS = 3;
  localparam int COUNT_BITS  = $clog2(CAPACITY + 1);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_SORTED = 3'd0,
    CMD_HEAD   = 3'd1,
    CMD_TAIL   = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_FIND   = 3'd4
  } skt_cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_NO_POS    = 3'd4
  } skt_status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } skt_state_t;

  // per-command controls broadcast to every cell
  typedef struct packed {
    logic commit;  // update cycle fires, cells may load
    logic walk;    // sorted insert walk mode
    logic del;     // delete command
  } skt_op_t;

  // signals rippled from one cell to its right neighbor
  typedef struct packed {
    logic seen;   // a hit occurred at a lower position
    logic mark;   // neighbor makes me the insertion point
    logic shift;  // insertion point lies at a lower position
    logic del;    // delete point lies at a lower position
  } skt_chain_t;

  // per-cell status seen by the controller
  typedef struct packed {
    logic lt;     // search key below this cell's key
    logic gt;     // search key above this cell's key
    logic first;  // first hit in the row
    logic dup;    // first hit of a sorted walk is an equal key
    logic mark;   // this cell is the insertion point
  } skt_flags_t;

endpackage

// ===== src/skt_cell.sv =====
// one position of the sorted key table: key, handle and compare flags
// depends on skt_pkg; instantiated in a row by sorted_key_table
module skt_cell import skt_pkg::*; (
  input  logic                   clk,
  input  logic                   cmp_en,
  input  logic [KEY_BITS-1:0]    cmp_key,
  input  skt_op_t                op,
  input  logic                   occ,
  input  logic                   right_lt,
  input  logic                   direct_mark,
  input  logic [KEY_BITS-1:0]    new_key,
  input  logic [HANDLE_BITS-1:0] new_handle,
  input  logic [KEY_BITS-1:0]    left_key,
  input  logic [HANDLE_BITS-1:0] left_handle,
  input  logic [KEY_BITS-1:0]    right_key,
  input  logic [HANDLE_BITS-1:0] right_handle,
  input  skt_chain_t             chain_in,
  output skt_chain_t             chain_out,
  output skt_flags_t             flags,
  output logic [KEY_BITS-1:0]    key,
  output logic [HANDLE_BITS-1:0] handle
);

  logic [KEY_BITS-1:0]    key_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic                   eq_r, lt_r, gt_r;
  logic                   hit, first, mark;

  // compare against the incoming key when a transaction is accepted
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      eq_r <= (cmp_key == key_r);
      lt_r <= (cmp_key < key_r);
      gt_r <= (cmp_key > key_r);
    end
  end

  // hit: equal key, or in a sorted walk the next key is larger
  always_comb begin
    hit   = occ & (eq_r | (op.walk & right_lt));
    first = hit & ~chain_in.seen;
    mark  = direct_mark | chain_in.mark;
  end

  // ripple to the right neighbor
  always_comb begin
    chain_out.seen  = chain_in.seen | hit;
    chain_out.mark  = op.walk & first & ~eq_r;
    chain_out.shift = chain_in.shift | mark;
    chain_out.del   = chain_in.del | first;
  end

  always_comb begin
    flags.lt    = lt_r;
    flags.gt    = gt_r;
    flags.first = first;
    flags.dup   = op.walk & first & eq_r;
    flags.mark  = mark;
  end

  // entry update: insert opens a gap, delete closes one
  always_ff @(posedge clk) begin
    if (op.commit) begin
      if (op.del) begin
        if (chain_in.del | first) begin
          key_r    <= right_key;
          handle_r <= right_handle;
        end
      end else if (mark) begin
        key_r    <= new_key;
        handle_r <= new_handle;
      end else if (chain_in.shift) begin
        key_r    <= left_key;
        handle_r <= left_handle;
      end
    end
  end

  assign key    = key_r;
  assign handle = handle_r;

endmodule

// ===== src/sorted_key_table.sv =====
// sorted key table: command sequencer, row of skt_cell and result register
// depends on skt_pkg, skt_cell and assert_macros.svh
//
// Usage: one command per input transaction (in_command, in_search_key,
// in_book_handle) on a valid/ready channel; every command gives exactly one
// result transaction (out_status, out_found_handle, out_prev_handle,
// out_entry_count) on a valid/ready output channel.
// Order: the cycle of acceptance registers the key compare in every cell;
// the update step that follows resolves the position along the cell row,
// shifts the entries and loads the result register. A new command is taken
// only once that compare-then-shift step is done, in the idle state.
// Result valid is registered, set when the update step fires.
// Stalls: a new command is accepted while a result waits in the output
// register; the update cycle of that command holds until the register is
// free, so a stalled receiver stalls the input after at most one command.
// Reset: synchronous active low; clears the entry count, the sequencer and
// the output valid. Entry storage is not cleared; only occupied positions
// are ever consulted.
`include "assert_macros.svh"
module sorted_key_table import skt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CMD_BITS-1:0]    in_command,
  input  logic [KEY_BITS-1:0]    in_search_key,
  input  logic [HANDLE_BITS-1:0] in_book_handle,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_BITS-1:0] out_status,
  output logic [HANDLE_BITS-1:0] out_found_handle,
  output logic [HANDLE_BITS-1:0] out_prev_handle,
  output logic [COUNT_BITS-1:0]  out_entry_count
);

  skt_state_t             state_r, state_nxt;
  logic [CMD_BITS-1:0]    cmd_r;
  logic [KEY_BITS-1:0]    key_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;

  logic                   out_valid_r;
  skt_status_t            out_status_r;
  logic [HANDLE_BITS-1:0] out_found_r, out_prev_r;

  logic in_fire, exec_fire;
  logic full, is_sorted, is_head, is_tail, is_del, is_find, is_ins, cmd_known;
  logic case_head, case_tail, gt_last, dup_any, seen_last;
  logic direct_head, direct_tail;
  skt_op_t op;

  logic [CAPACITY:0]   occ;
  logic [CAPACITY-1:0] tail_vec, last_vec, gt_vec, first_vec, dup_vec, mark_vec;
  logic [CAPACITY-1:0] right_lt_vec, direct_vec, prev_sel;

  skt_chain_t             chain [CAPACITY+1];
  skt_flags_t             flags [CAPACITY];
  logic [KEY_BITS-1:0]    key_q [CAPACITY];
  logic [HANDLE_BITS-1:0] handle_q [CAPACITY];

  skt_status_t            status_c;
  logic [HANDLE_BITS-1:0] found_c, prev_c;
  logic                   inserted_c, removed_c;

  // handshakes
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign exec_fire = (state_r == S_EXEC) & (~out_valid_r | out_ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= in_command;
      key_r    <= in_search_key;
      handle_r <= in_book_handle;
    end
  end

  // command decode
  always_comb begin
    is_sorted = (cmd_r == CMD_SORTED);
    is_head   = (cmd_r == CMD_HEAD);
    is_tail   = (cmd_r == CMD_TAIL);
    is_del    = (cmd_r == CMD_DELETE);
    is_find   = (cmd_r == CMD_FIND);
    is_ins    = is_sorted | is_head | is_tail;
    cmd_known = is_ins | is_del | is_find;
    full      = (count_r == COUNT_BITS'(CAPACITY));
  end

  // position decode from the entry count
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_pos
      assign occ[i] = (COUNT_BITS'(i) < count_r);
      if (i == 0) begin : g_first
        assign tail_vec[i] = ~occ[i];
      end else begin : g_rest
        assign tail_vec[i] = occ[i-1] & ~occ[i];
      end
      assign last_vec[i] = occ[i] & ~occ[i+1];
    end
  endgenerate
  assign occ[CAPACITY] = 1'b0;

  // insert at either end of the table: head and tail commands, or a sorted insert past either end
  assign case_head   = (count_r == '0) | (flags[0].lt & occ[0]);
  assign gt_last     = |(gt_vec & last_vec);
  assign case_tail   = ~case_head & gt_last;
  assign direct_head = ~full & (is_head | (is_sorted & case_head));
  assign direct_tail = ~full & (is_tail | (is_sorted & case_tail));

  always_comb begin
    op.commit = exec_fire;
    op.walk   = is_sorted & ~full & ~case_head & ~case_tail;
    op.del    = is_del;
  end

  // cell row
  assign chain[0] = '0;

  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_BITS-1:0]    lk, rk;
      logic [HANDLE_BITS-1:0] lh, rh;

      if (i == 0) begin : g_left_edge
        assign lk = key_r;
        assign lh = handle_r;
      end else begin : g_left
        assign lk = key_q[i-1];
        assign lh = handle_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_right_edge
        assign rk              = key_q[i];
        assign rh              = handle_q[i];
        assign right_lt_vec[i] = 1'b0;
        assign prev_sel[i]     = first_vec[0] & last_vec[i];
      end else begin : g_right
        assign rk              = key_q[i+1];
        assign rh              = handle_q[i+1];
        assign right_lt_vec[i] = flags[i+1].lt & occ[i+1];
        assign prev_sel[i]     = first_vec[i+1] | (first_vec[0] & last_vec[i]);
      end

      assign direct_vec[i] = ((i == 0) & direct_head) | (tail_vec[i] & direct_tail);

      skt_cell u_cell (
        .clk          (clk),
        .cmp_en       (in_fire),
        .cmp_key      (in_search_key),
        .op           (op),
        .occ          (occ[i]),
        .right_lt     (right_lt_vec[i]),
        .direct_mark  (direct_vec[i]),
        .new_key      (key_r),
        .new_handle   (handle_r),
        .left_key     (lk),
        .left_handle  (lh),
        .right_key    (rk),
        .right_handle (rh),
        .chain_in     (chain[i]),
        .chain_out    (chain[i+1]),
        .flags        (flags[i]),
        .key          (key_q[i]),
        .handle       (handle_q[i])
      );

      assign gt_vec[i]    = flags[i].gt;
      assign first_vec[i] = flags[i].first;
      assign dup_vec[i]   = flags[i].dup;
      assign mark_vec[i]  = flags[i].mark;
    end
  endgenerate

  assign seen_last = chain[CAPACITY].seen;
  assign dup_any   = |dup_vec;

  // handle select for find
  always_comb begin
    found_c = '0;
    prev_c  = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      found_c = found_c | ({HANDLE_BITS{first_vec[k]}} & handle_q[k]);
      prev_c  = prev_c | ({HANDLE_BITS{prev_sel[k]}} & handle_q[k]);
    end
  end

  // result status
  always_comb begin
    status_c   = ST_OK;
    inserted_c = 1'b0;
    removed_c  = 1'b0;
    if (!cmd_known) begin
      status_c = ST_NO_POS;
    end else if (is_ins & full) begin
      status_c = ST_FULL;
    end else begin
      case (cmd_r)
        CMD_SORTED: begin
          if (case_head | case_tail) begin
            inserted_c = 1'b1;
          end else if (!seen_last) begin
            status_c = ST_NO_POS;
          end else if (dup_any) begin
            status_c = ST_DUP;
          end else begin
            inserted_c = 1'b1;
          end
        end
        CMD_HEAD, CMD_TAIL: begin
          inserted_c = 1'b1;
        end
        CMD_DELETE: begin
          if (seen_last) removed_c = 1'b1;
          else status_c = ST_NOT_FOUND;
        end
        CMD_FIND: begin
          if (!seen_last) status_c = ST_NOT_FOUND;
        end
        default: status_c = ST_NO_POS;
      endcase
    end
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (exec_fire) begin
      if (inserted_c) count_nxt = count_r + COUNT_BITS'(1);
      else if (removed_c) count_nxt = count_r - COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_status_r <= status_c;
      out_found_r  <= (is_find & seen_last) ? found_c : '0;
      out_prev_r   <= (is_find & seen_last) ? prev_c : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_handle = out_found_r;
  assign out_prev_handle  = out_prev_r;
  assign out_entry_count  = count_r;

  // checks
  `SKT_ASSERT(a_count_cap, count_r <= COUNT_BITS'(CAPACITY), "entry count above capacity")
  `SKT_ASSERT(a_one_insert_point, exec_fire |-> $onehot0(mark_vec), "several insertion points")
  `SKT_ASSERT_NEXT(a_count_hold, !exec_fire, $stable(count_r), "count moved without update")
  `SKT_ASSERT(a_full_status, (out_valid_r && out_status_r == ST_FULL) |-> (count_r == COUNT_BITS'(CAPACITY)), "full status with room left")

endmodule

// ===== bench/tb_sorted_key_table.sv =====
`timescale 1ns / 1ps
// self-checking bench for sorted_key_table: directed and random command transactions
// with an in-bench model of the ordered table; depends on skt_pkg and the rtl only
module tb_sorted_key_table;
  import skt_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS      = 530;
  localparam logic [KEY_BITS-1:0] KEY_MAX = '1;
  // command codes past the last defined one
  localparam logic [CMD_BITS-1:0] CMD_RESERVED_LO = CMD_FIND + 1'b1;
  localparam logic [CMD_BITS-1:0] CMD_RESERVED_HI = '1;

  typedef struct {
    logic [CMD_BITS-1:0]    cmd;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
  } table_cmd_t;

  typedef struct {
    skt_status_t            status;
    logic [HANDLE_BITS-1:0] found;
    logic [HANDLE_BITS-1:0] prev;
    logic [COUNT_BITS-1:0]  count;
  } table_reply_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CMD_BITS-1:0]    in_command = '0;
  logic [KEY_BITS-1:0]    in_search_key = '0;
  logic [HANDLE_BITS-1:0] in_book_handle = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_BITS-1:0] out_status;
  logic [HANDLE_BITS-1:0] out_found_handle;
  logic [HANDLE_BITS-1:0] out_prev_handle;
  logic [COUNT_BITS-1:0]  out_entry_count;

  table_cmd_t             pending_cmds[$];
  table_reply_t           predicted_replies[$];
  logic [KEY_BITS-1:0]    table_keys[$];
  logic [HANDLE_BITS-1:0] table_handles[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          long_hold_armed = 1'b0;
  bit          long_hold_taken = 1'b0;

  sorted_key_table u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_search_key    (in_search_key),
    .in_book_handle   (in_book_handle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_found_handle (out_found_handle),
    .out_prev_handle  (out_prev_handle),
    .out_entry_count  (out_entry_count)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // table model: applies one command and returns the reply it owes
  function automatic table_reply_t table_step(input table_cmd_t c);
    table_reply_t r;
    int n;
    int pos;
    int nxt;
    bit done;
    r.status = ST_OK;
    r.found  = '0;
    r.prev   = '0;
    n = table_keys.size();
    pos = -1;
    for (int i = 0; i < n; i++) begin
      if (pos < 0 && table_keys[i] == c.key) pos = i;
    end
    if ((c.cmd == CMD_SORTED || c.cmd == CMD_HEAD || c.cmd == CMD_TAIL) && n >= CAPACITY) begin
      r.status = ST_FULL;
    end else begin
      case (c.cmd)
        CMD_SORTED: begin
          if (n == 0 || c.key < table_keys[0]) begin
            table_keys.push_front(c.key);
            table_handles.push_front(c.handle);
          end else if (c.key > table_keys[n-1]) begin
            table_keys.push_back(c.key);
            table_handles.push_back(c.handle);
          end else begin
            // walk from the head, wrapping at the tail
            done = 1'b0;
            r.status = ST_NO_POS;
            for (int i = 0; i < n && !done; i++) begin
              nxt = (i + 1 < n) ? i + 1 : 0;
              if (c.key == table_keys[i]) begin
                r.status = ST_DUP;
                done = 1'b1;
              end else if (c.key < table_keys[nxt]) begin
                table_keys.insert(i + 1, c.key);
                table_handles.insert(i + 1, c.handle);
                r.status = ST_OK;
                done = 1'b1;
              end
            end
          end
        end
        CMD_HEAD: begin
          table_keys.push_front(c.key);
          table_handles.push_front(c.handle);
        end
        CMD_TAIL: begin
          table_keys.push_back(c.key);
          table_handles.push_back(c.handle);
        end
        CMD_DELETE: begin
          if (pos >= 0) begin
            table_keys.delete(pos);
            table_handles.delete(pos);
          end else begin
            r.status = ST_NOT_FOUND;
          end
        end
        CMD_FIND: begin
          if (pos >= 0) begin
            r.found = table_handles[pos];
            r.prev  = table_handles[(pos == 0) ? n - 1 : pos - 1];
          end else begin
            r.status = ST_NOT_FOUND;
          end
        end
        default: r.status = ST_NO_POS;
      endcase
    end
    r.count = COUNT_BITS'(table_keys.size());
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic queue_cmd(input logic [CMD_BITS-1:0] cmd, input logic [KEY_BITS-1:0] key,
                           input logic [HANDLE_BITS-1:0] handle);
    table_cmd_t c;
    c.cmd    = cmd;
    c.key    = key;
    c.handle = handle;
    pending_cmds.push_back(c);
  endtask

  // mostly a small key pool so hits, duplicates and deletes are common
  function automatic logic [KEY_BITS-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return KEY_BITS'($urandom_range(0, 23));
    if (r < 85) return KEY_MAX - KEY_BITS'($urandom_range(0, 7));
    return KEY_BITS'($urandom());
  endfunction

  // alternate fill-heavy and drain-heavy stretches so the table swings empty to full
  task automatic queue_random(input int count);
    int unsigned r;
    bit filling;
    logic [CMD_BITS-1:0] cmd;
    for (int i = 0; i < count; i++) begin
      filling = ((i / 48) % 2) == 0;
      r = $urandom_range(0, 99);
      if (filling) begin
        if (r < 45)      cmd = CMD_SORTED;
        else if (r < 57) cmd = CMD_HEAD;
        else if (r < 69) cmd = CMD_TAIL;
        else if (r < 82) cmd = CMD_DELETE;
        else if (r < 98) cmd = CMD_FIND;
        else             cmd = CMD_BITS'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
      end else begin
        if (r < 15)      cmd = CMD_SORTED;
        else if (r < 20) cmd = CMD_HEAD;
        else if (r < 25) cmd = CMD_TAIL;
        else if (r < 70) cmd = CMD_DELETE;
        else if (r < 99) cmd = CMD_FIND;
        else             cmd = CMD_BITS'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
      end
      queue_cmd(cmd, pick_key(), HANDLE_BITS'($urandom()));
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid || predicted_replies.size() != 0)
      @(posedge clk);
  endtask

  // driver: predicts on acceptance, then offers the next pending transaction
  always @(posedge clk) begin : driver
    table_cmd_t taken;
    table_cmd_t next_cmd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken.cmd    = in_command;
        taken.key    = in_search_key;
        taken.handle = in_book_handle;
        predicted_replies.push_back(table_step(taken));
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_cmd = pending_cmds.pop_front();
          in_command     <= next_cmd.cmd;
          in_search_key  <= next_cmd.key;
          in_book_handle <= next_cmd.handle;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_hold_armed && !long_hold_taken) begin
      long_hold_taken <= 1'b1;
      hold_left       <= LONG_HOLD_CYCLES;
      out_ready       <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin : monitor
    table_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_replies.size() == 0) begin
        $error("result transaction with no command outstanding");
        mismatch_count++;
      end else begin
        want = predicted_replies.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("found_handle", 32'(want.found), 32'(out_found_handle));
        check_field("prev_handle", 32'(want.prev), 32'(out_prev_handle));
        check_field("entry_count", 32'(want.count), 32'(out_entry_count));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sorted_key_table test failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty table misses
    queue_cmd(CMD_FIND, 31'd7, 16'h0001);
    queue_cmd(CMD_DELETE, 31'd7, 16'h0002);
    // single entry: the previous entry is the match itself
    queue_cmd(CMD_SORTED, 31'd1000, 16'h1111);
    queue_cmd(CMD_FIND, 31'd1000, 16'h0000);
    // below head, above tail, middle, duplicate
    queue_cmd(CMD_SORTED, 31'd0, 16'h0000);
    queue_cmd(CMD_SORTED, KEY_MAX, 16'hFFFF);
    queue_cmd(CMD_SORTED, 31'd500, 16'hA5A5);
    queue_cmd(CMD_SORTED, 31'd500, 16'h5A5A);
    // match at the head wraps to the tail
    queue_cmd(CMD_FIND, 31'd0, 16'h0000);
    // head and tail inserts break the order, then a sorted walk through it
    queue_cmd(CMD_HEAD, 31'd2000, 16'h2000);
    queue_cmd(CMD_TAIL, 31'd5000, 16'h5000);
    queue_cmd(CMD_SORTED, 31'd3000, 16'h3000);
    // head insert skips the duplicate test; find and delete take the first match
    queue_cmd(CMD_HEAD, 31'd500, 16'h0BAD);
    queue_cmd(CMD_FIND, 31'd500, 16'h0000);
    queue_cmd(CMD_DELETE, 31'd500, 16'h0000);
    // fill up to capacity
    for (int i = 0; i < 9; i++)
      queue_cmd((i % 2) ? CMD_TAIL : CMD_HEAD, KEY_BITS'(100 + i), HANDLE_BITS'($urandom()));
    // full is reported before any duplicate test
    queue_cmd(CMD_SORTED, 31'd1000, 16'h7777);
    queue_cmd(CMD_HEAD, 31'd1, 16'h7777);
    queue_cmd(CMD_TAIL, 31'd2, 16'h7777);
    for (int c = CMD_RESERVED_LO; c <= CMD_RESERVED_HI; c++)
      queue_cmd(CMD_BITS'(c), 31'd3000, 16'hFFFF);
    queue_cmd(CMD_DELETE, KEY_MAX, 16'h0000);
    wait_drained();

    // random phases; each drains fully before the next
    send_idle_pct <= 8;
    recv_idle_pct <= 79;
    queue_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct <= 79;
    recv_idle_pct <= 8;
    queue_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    queue_random(PHASE_ITEMS);
    long_hold_armed <= 1'b1;
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && predicted_replies.size() == 0)
      $display("sorted_key_table test passed");
    else
      $display("sorted_key_table test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/skt_pkg.sv
src/skt_cell.sv
src/sorted_key_table.sv
bench/tb_sorted_key_table.sv
